// ===== sv/cqrbv_pkg.sv =====
`timescale 1ns / 1ps

package cqrbv_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned OUT_DW    = 40;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ = 2'd0,
    REQ_DEQ = 2'd1,
    REQ_RM  = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEQ,
    ST_RM
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic deq_load;
    logic rm_run;
    logic rm_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic rm_done;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/cqrbv_ctrl.sv =====
`timescale 1ns / 1ps

module cqrbv_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [cqrbv_pkg::REQ_W-1:0]    in_req_i,
  input  cqrbv_pkg::sts_t                sts_i,
  output logic                           in_ready_o,
  output cqrbv_pkg::cmd_t                cmd_o
);
  import cqrbv_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !sts_i.empty) begin
          if (in_req_i == REQ_DEQ) begin
            state_d = ST_DEQ;
          end else if (in_req_i == REQ_RM) begin
            state_d = ST_RM;
          end
        end
      end
      ST_DEQ: begin
        state_d = ST_IDLE;
      end
      ST_RM: begin
        if (sts_i.rm_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = accept;
      end
      ST_DEQ: begin
        cmd_o.deq_load = 1'b1;
      end
      ST_RM: begin
        cmd_o.rm_run  = !sts_i.rm_done;
        cmd_o.rm_load = sts_i.rm_done;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/cqrbv_dp.sv =====
`timescale 1ns / 1ps

module cqrbv_dp #(
  parameter int unsigned DEPTH = cqrbv_pkg::DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cqrbv_pkg::cmd_t                cmd_i,
  input  logic [cqrbv_pkg::REQ_W-1:0]    in_req_i,
  input  logic [cqrbv_pkg::VAL_W-1:0]    in_value_i,
  input  logic                           out_ready_i,
  output cqrbv_pkg::sts_t                sts_o,
  output logic                           out_valid_o,
  output logic [cqrbv_pkg::STAT_W-1:0]   out_status_o,
  output logic [cqrbv_pkg::VAL_W-1:0]    out_value_o,
  output logic [cqrbv_pkg::CNT_W-1:0]    out_removed_o,
  output logic [cqrbv_pkg::CNT_W-1:0]    out_occ_o
);
  import cqrbv_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    nxt = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_q;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [AW-1:0] rm_cnt_q, rm_cnt_d;
  logic          pend_q, pend_d;
  logic [VAL_W-1:0] match_q, match_d;

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [VAL_W-1:0] wr_data;

  logic             out_load, out_valid_q;
  stat_e            ld_status;
  logic [VAL_W-1:0] ld_value;
  logic [AW-1:0]    ld_removed;
  logic [AW:0]      occ_sum;
  logic [AW+CNT_W-1:0] occ_ext, rm_ext;

  assign sts_o.empty    = (head_q == tail_q);
  assign sts_o.full     = (nxt(tail_q) == head_q);
  assign sts_o.rm_done  = (rp_q == tail_q) && !pend_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    rp_d       = rp_q;
    wp_d       = wp_q;
    rm_cnt_d   = rm_cnt_q;
    pend_d     = pend_q;
    match_d    = match_q;
    wr_en      = 1'b0;
    wr_addr    = tail_q;
    wr_data    = in_value_i;
    rd_en      = 1'b0;
    rd_addr    = head_q;
    out_load   = 1'b0;
    ld_status  = STAT_DONE;
    ld_value   = '0;
    ld_removed = '0;

    if (cmd_i.accept) begin
      case (in_req_i)
        REQ_ENQ: begin
          out_load = 1'b1;
          if (sts_o.full) begin
            ld_status = STAT_FULL;
          end else begin
            wr_en  = 1'b1;
            tail_d = nxt(tail_q);
          end
        end
        REQ_DEQ: begin
          if (sts_o.empty) begin
            out_load  = 1'b1;
            ld_status = STAT_EMPTY;
          end else begin
            rd_en  = 1'b1;
            head_d = nxt(head_q);
          end
        end
        REQ_RM: begin
          if (sts_o.empty) begin
            out_load  = 1'b1;
            ld_status = STAT_EMPTY;
          end else begin
            rp_d     = head_q;
            wp_d     = head_q;
            rm_cnt_d = '0;
            pend_d   = 1'b0;
            match_d  = in_value_i;
          end
        end
        default: begin
          out_load = 1'b1;
        end
      endcase
    end

    if (cmd_i.deq_load) begin
      out_load = 1'b1;
      ld_value = rd_data_q;
    end

    // Compaction: survivors are written back behind the read pointer, so the
    // write pointer always trails and never clobbers an unread entry.
    if (cmd_i.rm_run) begin
      if (rp_q != tail_q) begin
        rd_en   = 1'b1;
        rd_addr = rp_q;
        rp_d    = nxt(rp_q);
        pend_d  = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
      if (pend_q) begin
        if (rd_data_q != match_q) begin
          wr_en   = 1'b1;
          wr_addr = wp_q;
          wr_data = rd_data_q;
          wp_d    = nxt(wp_q);
        end else begin
          rm_cnt_d = rm_cnt_q + 1'b1;
        end
      end
    end

    if (cmd_i.rm_load) begin
      out_load   = 1'b1;
      tail_d     = wp_q;
      ld_removed = rm_cnt_q;
    end
  end

  // Fill level after the update: (tail - head) mod DEPTH.
  assign occ_sum = {1'b0, tail_d} - {1'b0, head_d}
                   + ((tail_d < head_d) ? (AW+1)'(DEPTH) : '0);
  assign occ_ext = {{CNT_W{1'b0}}, occ_sum[AW-1:0]};
  assign rm_ext  = {{CNT_W{1'b0}}, ld_removed};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      rp_q        <= '0;
      wp_q        <= '0;
      rm_cnt_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      rp_q     <= rp_d;
      wp_q     <= wp_d;
      rm_cnt_q <= rm_cnt_d;
      pend_q   <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    if (out_load) begin
      out_status_o  <= ld_status;
      out_value_o   <= ld_value;
      out_removed_o <= rm_ext[CNT_W-1:0];
      out_occ_o     <= occ_ext[CNT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/circular_queue_with_remove_by_value_top.sv =====
`timescale 1ns / 1ps
// Enqueue, no-op and refused requests load the result register in the cycle of acceptance.
// A dequeue passes through the registered read port of the slot memory, then the result register.
// Remove compacts the occupied slots, reading one slot per cycle through the same port.
// Throughput: one enqueue per cycle while the result side keeps up; a dequeue holds the
// input off until its result is loaded, and a remove until its compaction pass ends.
// Reset (rst_ni low, asynchronous) empties the queue; slot contents are not cleared.
module circular_queue_with_remove_by_value_top #(
  parameter int unsigned DEPTH = cqrbv_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request channel.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cqrbv_pkg::VAL_W-1:0]     s_axis_tdata,  // [31:0] value
  input  logic [cqrbv_pkg::REQ_W-1:0]     s_axis_tuser,  // [1:0] req_type
  // Result channel.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] out_value, [35:32] removed_count, [39:36] occupancy
  output logic [cqrbv_pkg::OUT_DW-1:0]    m_axis_tdata,
  output logic [cqrbv_pkg::STAT_W-1:0]    m_axis_tuser   // [1:0] status
);
  import cqrbv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [VAL_W-1:0] out_value;
  logic [CNT_W-1:0] out_removed;
  logic [CNT_W-1:0] out_occ;

  // The controller sequences dequeue and the remove compaction pass; it only
  // admits a new item when the result register is empty or draining, so every
  // completing item finds room for its result.
  cqrbv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_req_i   (s_axis_tuser),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // The datapath holds the slot memory, the head and tail pointers, the
  // compaction pointers and the result register.
  cqrbv_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_req_i      (s_axis_tuser),
    .in_value_i    (s_axis_tdata),
    .out_ready_i   (m_axis_tready),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_status_o  (m_axis_tuser),
    .out_value_o   (out_value),
    .out_removed_o (out_removed),
    .out_occ_o     (out_occ)
  );

  assign m_axis_tdata = {out_occ, out_removed, out_value};

endmodule

// ===== sv/cqrbv_chk.sv =====
`timescale 1ns / 1ps

module cqrbv_chk #(
  parameter int unsigned DEPTH = cqrbv_pkg::DEPTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_i,
  input logic                          m_axis_tvalid_i,
  input logic                          m_axis_tready_i,
  input logic [cqrbv_pkg::OUT_DW-1:0]  m_axis_tdata_i,
  input logic [cqrbv_pkg::STAT_W-1:0]  m_axis_tuser_i
);
  import cqrbv_pkg::*;

  localparam logic [31:0] FULL_OCC = 32'(DEPTH - 1);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)
    else $error("result item dropped while stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_i |-> !m_axis_tvalid_i || m_axis_tready_i)
    else $error("item admitted while result register is held");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tuser_i != 2'd3)
    else $error("undefined status code");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i == STAT_EMPTY |->
      m_axis_tdata_i == '0)
    else $error("empty result carries data");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i == STAT_FULL |->
      m_axis_tdata_i[39:36] == FULL_OCC[3:0] && m_axis_tdata_i[35:0] == '0)
    else $error("full result with wrong occupancy");

endmodule

bind circular_queue_with_remove_by_value_top cqrbv_chk #(
  .DEPTH (DEPTH)
) u_cqrbv_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_i (s_axis_tready),
  .m_axis_tvalid_i (m_axis_tvalid),
  .m_axis_tready_i (m_axis_tready),
  .m_axis_tdata_i  (m_axis_tdata),
  .m_axis_tuser_i  (m_axis_tuser)
);
